/* rtl/core/firs_pkg.sv */
// Shared types, constants and the coefficient function for the saturating FIR filter.
// Used by the sequencer, the coefficient ROM, the MAC datapath and the top level.
// No dependencies.
`default_nettype none

package firs_pkg;

  // Sample format on both channels.
  localparam int SAMPLE_W = 16;

  // Default filter size and coefficient precision (Q1.15).
  localparam int DEFAULT_TAPS           = 63;
  localparam int DEFAULT_COEF_FRAC_BITS = 15;

  // Bandpass coefficients in units of 1e-7, symmetric, centred near 5 kHz.
  localparam int TABLE_LEN = 63;
  localparam longint DEC_SCALE = 10000000;

  localparam int COEF_DEC [TABLE_LEN] = '{
    730925, 1005570, -1322851, 954512, 754908,
    915603, 366887, -113547, -512040, -602071,
    -419634, -59188, 298679, 497159, 453203,
    197406, -152828, -427857, -494711, -323446,
    8235, 340080, 511223, 433663, 142687,
    -223644, -484856, -508951, -287151, 78560,
    407296, 536207, 407296, 78560, -287151,
    -508951, -484856, -223644, 142687, 433663,
    511223, 340080, 8235, -323446, -494711,
    -427857, -152828, 197406, 453203, 497159,
    298679, -59188, -419634, -602071, -512040,
    -113547, 366887, 915603, 754908, 954512,
    -1322851, 1005570, 730925
  };

  // Control that travels with one tap through the MAC pipeline.
  typedef struct packed {
    logic valid;     // a tap is issued this cycle
    logic first;     // first tap of a sample: restart the accumulator
    logic last;      // last tap of a sample
    logic use_x;     // tap zero: take the new sample instead of memory data
    logic in_range;  // the delay-line entry has been written since reset
  } tap_ctl_t;

  // Coefficient k in fixed point with frac_bits fractional bits, rounded to
  // nearest with ties away from zero. Taps past the table are zero. Evaluated
  // at elaboration only.
  function automatic longint coef_q(input int k, input int frac_bits);
    longint mag;
    longint num;
    longint q;
    if (k >= TABLE_LEN) begin
      return 0;
    end
    mag = (COEF_DEC[k] < 0) ? -longint'(COEF_DEC[k]) : longint'(COEF_DEC[k]);
    num = mag << frac_bits;
    q   = (2 * num + DEC_SCALE) / (2 * DEC_SCALE);
    return (COEF_DEC[k] < 0) ? -q : q;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/firs_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Holds the delay line of the FIR filter. No dependencies.
`default_nettype none

module firs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 62,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/firs_coef_rom.sv */
// Coefficient ROM of the FIR filter with a registered read, one tap per cycle.
// Depends on firs_pkg for the coefficient table and its rounding function.
`default_nettype none

module firs_coef_rom
  import firs_pkg::*;
#(
  parameter int TAPS           = DEFAULT_TAPS,
  parameter int COEF_FRAC_BITS = DEFAULT_COEF_FRAC_BITS,
  localparam int K_W    = $clog2(TAPS),
  localparam int COEF_W = COEF_FRAC_BITS + 1
) (
  input  wire logic                     clk,
  input  wire logic        [K_W-1:0]    addr,
  output logic signed      [COEF_W-1:0] coef
);

  logic signed [COEF_W-1:0] rom [TAPS];

  // Constant contents, worked out at elaboration.
  for (genvar g = 0; g < TAPS; g++) begin : g_rom
    assign rom[g] = COEF_W'(coef_q(g, COEF_FRAC_BITS));
  end

  // Registered read, aligned with the delay-line memory.
  always_ff @(posedge clk) begin
    coef <= rom[addr];
  end

endmodule

`default_nettype wire

/* rtl/core/firs_mac.sv */
// Multiply-accumulate datapath of the FIR filter: operand select, product
// register, accumulator, then truncation toward zero and saturation.
// Depends on firs_pkg for tap_ctl_t and the sample width.
`default_nettype none

module firs_mac
  import firs_pkg::*;
#(
  parameter int TAPS           = DEFAULT_TAPS,
  parameter int COEF_FRAC_BITS = DEFAULT_COEF_FRAC_BITS,
  localparam int COEF_W = COEF_FRAC_BITS + 1,
  localparam int PROD_W = SAMPLE_W + COEF_W,
  localparam int ACC_W  = PROD_W + $clog2(TAPS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tap_ctl_t                   issue,
  input  wire logic signed [SAMPLE_W-1:0] x,
  input  wire logic signed [SAMPLE_W-1:0] ram_q,
  input  wire logic signed [COEF_W-1:0]   coef,
  output logic                            done,
  output logic signed      [SAMPLE_W-1:0] result
);

  localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((2 ** COEF_FRAC_BITS) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(2 ** (SAMPLE_W - 1)));

  tap_ctl_t                   ctl1;
  tap_ctl_t                   ctl2;
  logic signed [SAMPLE_W-1:0] operand;
  logic signed [PROD_W-1:0]   prod_c;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    biased;
  logic signed [ACC_W-1:0]    shifted;

  // Control follows the memory read, then the product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      done <= 1'b0;
    end else begin
      ctl1 <= issue;
      ctl2 <= ctl1;
      done <= ctl2.valid & ctl2.last;
    end
  end

  // Operand select: new sample for tap zero, zero for entries older than reset.
  always_comb begin
    if (ctl1.use_x) begin
      operand = x;
    end else if (ctl1.in_range) begin
      operand = ram_q;
    end else begin
      operand = '0;
    end
  end

  assign prod_c = operand * coef;

  // Product register and accumulator.
  always_ff @(posedge clk) begin
    prod <= prod_c;
    if (ctl2.valid) begin
      if (ctl2.first) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // Divide by the coefficient scale, truncating toward zero, then saturate.
  assign biased  = acc[ACC_W-1] ? acc + BIAS : acc;
  assign shifted = biased >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > SAT_MAX) begin
      result = SAT_MAX[SAMPLE_W-1:0];
    end else if (shifted < SAT_MIN) begin
      result = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      result = shifted[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/firs_seq.sv */
// Tap sequencer of the FIR filter: input handshake, circular write pointer and
// fill count of the delay line, tap addresses and result hand-off.
// Depends on firs_pkg for tap_ctl_t and the sample width.
`default_nettype none

module firs_seq
  import firs_pkg::*;
#(
  parameter int TAPS = DEFAULT_TAPS,
  localparam int DEPTH  = TAPS - 1,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int K_W    = $clog2(TAPS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic signed [SAMPLE_W-1:0] s_tdata,
  output logic signed      [SAMPLE_W-1:0] x,
  output logic             [ADDR_W-1:0]   raddr,
  output logic             [ADDR_W-1:0]   waddr,
  output logic                            we,
  output logic             [K_W-1:0]      coef_addr,
  output tap_ctl_t                        issue,
  input  wire logic                       mac_done,
  input  wire logic                       out_free,
  output logic                            load
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [K_W-1:0]    LAST_TAP  = K_W'(TAPS - 1);
  localparam logic [K_W-1:0]    FULL      = K_W'(DEPTH);

  state_t            state;
  state_t            state_next;
  logic [K_W-1:0]    k;
  logic [K_W-1:0]    fill;
  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] rp;
  logic              last_d;
  logic              accept;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign raddr     = rp;
  assign waddr     = wp;
  assign we        = last_d;
  assign coef_addr = k;

  // Tap issued this cycle.
  always_comb begin
    issue.valid    = (state == S_RUN);
    issue.first    = (k == '0);
    issue.last     = (k == LAST_TAP);
    issue.use_x    = (k == '0);
    issue.in_range = (k <= fill);
  end

  // Result hand-off to the output register.
  assign load = ((state == S_DRAIN) && mac_done && out_free) ||
                ((state == S_HOLD) && out_free);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (k == LAST_TAP) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_next = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers: state, tap counter, pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      k      <= '0;
      fill   <= '0;
      wp     <= '0;
      last_d <= 1'b0;
    end else begin
      state  <= state_next;
      last_d <= issue.valid & issue.last;
      if (state == S_RUN) begin
        k <= (k == LAST_TAP) ? '0 : k + 1'b1;
      end
      // The new sample replaces the oldest entry once its last read is done.
      if (last_d) begin
        wp <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
        if (fill != FULL) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // Latched sample and read pointer walking back from the newest entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      x  <= s_tdata;
      rp <= (wp == '0) ? LAST_ADDR : wp - 1'b1;
    end else if ((state == S_RUN) && (k != '0)) begin
      rp <= (rp == '0) ? LAST_ADDR : rp - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fir_filter_int16_saturating.sv */
// Direct-form FIR filter for signed 16-bit samples, with saturated 16-bit output.
// Top level; depends on firs_pkg, firs_seq, firs_ram, firs_coef_rom and firs_mac.
//
// Usage: one sample enters per request on the s_ channel and exactly one
// filtered sample leaves per request on the m_ channel, in order. A request
// moves on a rising edge at which tvalid and tready are both high.
// Each sample is worked through one multiply-accumulate per tap, with the
// coefficient ROM and the delay-line memory each read once per cycle, then
// through the read, product and accumulate stages and the hand-off to the
// output register. One sample is worked on at a time: a new sample is taken
// only once the result of the last one has been handed off.
// The delay line sits in a circular memory of TAPS - 1 entries; a fill count
// makes entries not yet written since reset read as zero, so reset takes
// effect at once and needs no clearing pass.
// Reset clears the fill count, the write pointer, the sequencer and the output
// valid. When the receiver stalls, the finished sample waits in the output
// register; the next input sample is still taken and filtered, and its result
// waits inside the block until the output register is free.
`default_nettype none

module fir_filter_int16_saturating
  import firs_pkg::*;
#(
  parameter int TAPS           = DEFAULT_TAPS,
  parameter int COEF_FRAC_BITS = DEFAULT_COEF_FRAC_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic signed [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic signed      [SAMPLE_W-1:0] m_tdata    // [15:0] sample_out
);

  localparam int DEPTH  = TAPS - 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int K_W    = $clog2(TAPS);
  localparam int COEF_W = COEF_FRAC_BITS + 1;

  tap_ctl_t                   issue;
  logic signed [SAMPLE_W-1:0] x;
  logic        [ADDR_W-1:0]   raddr;
  logic        [ADDR_W-1:0]   waddr;
  logic                       we;
  logic        [K_W-1:0]      coef_addr;
  logic        [SAMPLE_W-1:0] ram_q;
  logic signed [COEF_W-1:0]   coef;
  logic                       mac_done;
  logic                       out_free;
  logic                       load;
  logic signed [SAMPLE_W-1:0] result;

  assign out_free = ~m_tvalid | m_tready;

  // Sequencer.
  firs_seq #(
    .TAPS (TAPS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .x         (x),
    .raddr     (raddr),
    .waddr     (waddr),
    .we        (we),
    .coef_addr (coef_addr),
    .issue     (issue),
    .mac_done  (mac_done),
    .out_free  (out_free),
    .load      (load)
  );

  // Delay-line memory.
  firs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (x),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Coefficient ROM.
  firs_coef_rom #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_coef_rom (
    .clk  (clk),
    .addr (coef_addr),
    .coef (coef)
  );

  // Multiply-accumulate and saturation.
  firs_mac #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .x      (x),
    .ram_q  (ram_q),
    .coef   (coef),
    .done   (mac_done),
    .result (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= result;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/fir_filter_int16_saturating_tb.sv */
// Self-checking testbench for the 63-tap saturating FIR filter on its stream ports.
// Depends on firs_pkg and the fir_filter_int16_saturating top level; predicts every
// output from its own bit-exact filter model and checks each result in order.
`timescale 1ns / 100ps

module fir_filter_int16_saturating_tb;
  import firs_pkg::*;

  localparam int NTAPS        = DEFAULT_TAPS;
  localparam int FRAC         = DEFAULT_COEF_FRAC_BITS;
  localparam int RANDOM_ITEMS = 900;
  // Request counts between which neither side idles.
  localparam int CALM_FROM    = 300;
  localparam int CALM_TO      = 450;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Kinds of stimulus segment in the random part.
  typedef enum int {
    SEG_UNIFORM,
    SEG_FULL_SCALE,
    SEG_PEAK_POS,
    SEG_PEAK_NEG,
    SEG_QUIET,
    SEG_SILENCE
  } seg_kind_t;

  logic    clk      = 1'b0;
  logic    rst      = 1'b1;
  logic    s_tvalid = 1'b0;
  logic    s_tready;
  sample_t s_tdata  = '0;
  logic    m_tvalid;
  logic    m_tready = 1'b0;
  sample_t m_tdata;

  // Filter state held by the predictor.
  longint  tap_coef [NTAPS];
  sample_t history  [NTAPS-1] = '{default: '0};

  sample_t pending_samples  [$];
  sample_t expected_outputs [$];

  int err_cnt      = 0;
  int accepted_cnt = 0;
  int received_cnt = 0;
  int sat_cnt      = 0;
  int stall_left   = 0;
  int longest_stall = 0;
  int directed_cnt  = 0;

  fir_filter_int16_saturating dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous limit; a correct run needs a small fraction of it.
  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    err_cnt++;
  endtask

  // Coefficient k in Q1.15, rounded to nearest with ties away from zero.
  function automatic longint round_coef(input int k);
    longint mag;
    longint q;
    if (k >= TABLE_LEN) begin
      return 0;
    end
    mag = (COEF_DEC[k] < 0) ? -longint'(COEF_DEC[k]) : longint'(COEF_DEC[k]);
    q   = ((mag <<< (FRAC + 1)) + DEC_SCALE) / (2 * DEC_SCALE);
    return (COEF_DEC[k] < 0) ? -q : q;
  endfunction

  // Filters one new sample, advances the delay line and returns the expected output.
  function automatic sample_t filter_sample(input sample_t x);
    longint  acc;
    longint  mag;
    sample_t y;
    acc = tap_coef[0] * longint'(x);
    for (int k = 1; k < NTAPS; k++) begin
      acc += tap_coef[k] * longint'(history[k-1]);
    end
    // Truncate toward zero, then saturate.
    mag = (acc < 0) ? -acc : acc;
    mag = mag >> FRAC;
    if (acc < 0) begin
      y = (mag > 32768) ? sample_t'(-32768) : sample_t'(-mag);
    end else begin
      y = (mag > 32767) ? sample_t'(32767) : sample_t'(mag);
    end
    if (y == 32767 || y == -32768) begin
      sat_cnt++;
    end
    for (int k = NTAPS - 2; k > 0; k--) begin
      history[k] = history[k-1];
    end
    history[0] = x;
    return y;
  endfunction

  // Queues len samples whose signs line up with the coefficients, so that at the
  // last of them each of these samples adds to the sum with the same sign.
  task automatic push_peak(input bit negative, input int len, input bit full_scale);
    int      amp;
    bit      up;
    sample_t v;
    amp = full_scale ? 32767 : $urandom_range(32767, 8000);
    for (int j = 0; j < len; j++) begin
      up = (tap_coef[len-1-j] >= 0) ^ negative;
      if (up) begin
        v = sample_t'(amp);
      end else begin
        v = (amp == 32767) ? sample_t'(-32768) : sample_t'(-amp);
      end
      pending_samples.push_back(v);
    end
  endtask

  // Sender: holds a request until it is taken, otherwise offers the next
  // sample unless it chooses to idle this cycle.
  always @(posedge clk) begin : sample_driver
    logic idle;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_outputs.push_back(filter_sample(s_tdata));
        accepted_cnt++;
      end
      if (!(s_tvalid && !s_tready)) begin
        idle = (accepted_cnt < CALM_FROM || accepted_cnt >= CALM_TO) &&
               ($urandom_range(99) < 36);
        if (pending_samples.size() > 0 && !idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_samples.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest prediction and stalls at
  // random, now and then for longer than one whole filter pass.
  always @(posedge clk) begin : result_monitor
    logic    ready_next;
    logic    calm;
    sample_t want;
    calm = (received_cnt >= CALM_FROM && received_cnt < CALM_TO);
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        received_cnt++;
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("output %0d with no sample pending", m_tdata));
        end else begin
          want = expected_outputs.pop_front();
          if (m_tdata !== want) begin
            report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                      received_cnt, m_tdata, want));
          end
        end
        if (!calm && $urandom_range(24) == 0) begin
          stall_left = $urandom_range(200, 70);
          if (stall_left > longest_stall) begin
            longest_stall = stall_left;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = calm || ($urandom_range(99) >= 36);
      end
      m_tready <= ready_next;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    seg_kind_t kind;
    int        len;
    int        total;
    for (int k = 0; k < NTAPS; k++) begin
      tap_coef[k] = round_coef(k);
    end

    // Directed part. With an empty delay line, -1 must give 0 (truncation
    // toward zero, not floor). The aligned run then saturates the output.
    pending_samples.push_back(sample_t'(-1));
    pending_samples.push_back(sample_t'(1));
    push_peak(1'b0, 20, 1'b1);
    pending_samples.push_back(sample_t'(32767));
    pending_samples.push_back(sample_t'(-32768));
    pending_samples.push_back(sample_t'(16'sh5555));
    pending_samples.push_back(sample_t'(16'shAAAA));
    pending_samples.push_back(sample_t'(0));
    directed_cnt = pending_samples.size();

    // Random part: segments of mixed character, many of them aligned runs
    // that push the sum into both saturation limits.
    while (pending_samples.size() < directed_cnt + RANDOM_ITEMS) begin
      kind = seg_kind_t'($urandom_range(SEG_SILENCE));
      len  = $urandom_range(40, 4);
      case (kind)
        SEG_UNIFORM: begin
          repeat (len) pending_samples.push_back(sample_t'($urandom));
        end
        SEG_FULL_SCALE: begin
          repeat (len) begin
            pending_samples.push_back($urandom_range(1) ? sample_t'(32767) :
                                                          sample_t'(-32768));
          end
        end
        SEG_PEAK_POS: begin
          push_peak(1'b0, NTAPS, 1'($urandom_range(1)));
        end
        SEG_PEAK_NEG: begin
          push_peak(1'b1, NTAPS, 1'($urandom_range(1)));
        end
        SEG_QUIET: begin
          repeat (len) pending_samples.push_back(sample_t'($urandom_range(511) - 256));
        end
        default: begin
          repeat ($urandom_range(70, 10)) pending_samples.push_back(sample_t'(0));
        end
      endcase
    end
    total = pending_samples.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait until every queued sample has produced its result.
    while (received_cnt < total) begin
      @(posedge clk);
    end
    // Let any stray result surface.
    repeat (200) @(posedge clk);
    if (expected_outputs.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_outputs.size()));
    end

    $display("Filtered %0d samples (%0d directed), checked %0d results, %0d saturated.",
             accepted_cnt, directed_cnt, received_cnt, sat_cnt);
    $display("Receiver stalls lasted up to %0d cycles; %0d mismatches.",
             longest_stall, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
